[src/fra_pkg.sv]
// ----------------------------------------------------------------------------
// fra_pkg
// types and constants shared by the fraction add and reduce unit
// ----------------------------------------------------------------------------
package fra_pkg;

  localparam int WIDTH = 16;
  localparam int NW    = 2 * WIDTH + 1;
  localparam int DW    = 2 * WIDTH;
  localparam int MW    = WIDTH + 1;
  localparam int AW    = 2 * MW;
  localparam int KW    = $clog2(NW + 1);
  localparam int CW    = $clog2(NW);

  typedef struct packed {
    logic signed [WIDTH-1:0] num_a;
    logic        [WIDTH-1:0] den_a;
    logic signed [WIDTH-1:0] num_b;
    logic        [WIDTH-1:0] den_b;
  } in_t;

  typedef struct packed {
    logic signed [NW-1:0] sum_num;
    logic        [DW-1:0] sum_den;
    logic                 same;
    logic                 bad_input;
  } out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_A,
    ST_MUL_B,
    ST_MUL_D,
    ST_CHECK,
    ST_GCD,
    ST_DIV_N,
    ST_DIV_D
  } state_t;

endpackage

[src/fra_sub.sv]
// ----------------------------------------------------------------------------
// fra_sub
// shared subtractor with borrow, used for compare, gcd and division steps
// ----------------------------------------------------------------------------
module fra_sub
  import fra_pkg::*;
(
  input  logic [AW-1:0] a,
  input  logic [AW-1:0] b,
  output logic [AW-1:0] diff,
  output logic          borrow
);

  assign {borrow, diff} = {1'b0, a} - {1'b0, b};

endmodule

[src/fra_mul.sv]
// ----------------------------------------------------------------------------
// fra_mul
// shared signed multiplier for the cross products and the denominator product
// ----------------------------------------------------------------------------
module fra_mul
  import fra_pkg::*;
(
  input  logic signed [MW-1:0] a,
  input  logic signed [MW-1:0] b,
  output logic signed [AW-1:0] p
);

  assign p = a * b;

endmodule

[src/fraction_add_reduce_unit.sv]
// ----------------------------------------------------------------------------
// fraction_add_reduce_unit
// adds two fractions and reduces the sum to lowest terms
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low. The unit forms the
// two cross products and the denominator product on one multiplier, one after
// another, then runs a binary gcd and two restoring divisions (one quotient
// bit per cycle) on one shared subtractor. The gcd loop runs as long as the
// operand values need and each division yields a 33-bit quotient; a zero sum or a zero
// denominator ends at the check, with no gcd or division. The result
// is shown for exactly one cycle with done high and cannot be held off, so
// the receiver must take it on that cycle.
// ----------------------------------------------------------------------------
module fraction_add_reduce_unit
  import fra_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  in_t  operands,
  output logic done,
  output out_t result
);

  state_t state, state_next;

  in_t                 op;
  logic signed [AW-1:0] prod;
  logic signed [AW-1:0] acc;
  logic [NW-1:0]       mag;
  logic [DW-1:0]       dreg;
  logic [NW-1:0]       u;
  logic [NW-1:0]       v;
  logic [KW-1:0]       k;
  logic [NW-1:0]       g;
  logic [NW-1:0]       rem;
  logic [NW-1:0]       quo;
  logic [NW-1:0]       qnum;
  logic [CW-1:0]       cnt;
  logic                neg;

  logic signed [MW-1:0] mul_a, mul_b;
  logic signed [AW-1:0] mul_p;
  logic [AW-1:0]       sub_a, sub_b, sub_d;
  logic                sub_borrow;
  logic [AW-1:0]       acc_mag;
  logic [NW-1:0]       quo_next;
  logic                same_w, bad_w, last_step;

  fra_mul u_mul (.a(mul_a), .b(mul_b), .p(mul_p));
  fra_sub u_sub (.a(sub_a), .b(sub_b), .diff(sub_d), .borrow(sub_borrow));

  assign same_w    = (op.num_a == op.num_b) && (op.den_a == op.den_b);
  assign bad_w     = (op.den_a == '0) || (op.den_b == '0);
  assign acc_mag   = acc[AW-1] ? -acc : acc;
  assign last_step = (cnt == CW'(NW - 1));
  assign quo_next  = {quo[NW-2:0], ~sub_borrow};

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:  if (start) state_next = ST_MUL_A;
      ST_MUL_A: state_next = ST_MUL_B;
      ST_MUL_B: state_next = ST_MUL_D;
      ST_MUL_D: state_next = ST_CHECK;
      ST_CHECK: begin
        if (bad_w || acc == '0) state_next = ST_IDLE;
        else state_next = ST_GCD;
      end
      ST_GCD:   if (u == '0) state_next = ST_DIV_N;
      ST_DIV_N: if (last_step) state_next = ST_DIV_D;
      ST_DIV_D: if (last_step) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // shared unit operand selection
  always_comb begin
    busy  = (state != ST_IDLE);
    mul_a = {op.num_a[WIDTH-1], op.num_a};
    mul_b = $signed({1'b0, op.den_b});
    sub_a = {1'b0, u};
    sub_b = {1'b0, v};
    case (state)
      ST_MUL_B: begin
        mul_a = {op.num_b[WIDTH-1], op.num_b};
        mul_b = $signed({1'b0, op.den_a});
      end
      ST_MUL_D: begin
        mul_a = $signed({1'b0, op.den_a});
        mul_b = $signed({1'b0, op.den_b});
      end
      ST_DIV_N, ST_DIV_D: begin
        sub_a = {rem, quo[NW-1]};
        sub_b = {1'b0, g};
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        ST_CHECK: if (bad_w || acc == '0) done <= 1'b1;
        ST_DIV_D: if (last_step) done <= 1'b1;
        default: begin
        end
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: if (start) op <= operands;
      ST_MUL_A: prod <= mul_p;
      ST_MUL_B: begin
        acc  <= prod;
        prod <= mul_p;
      end
      ST_MUL_D: begin
        acc  <= acc + prod;
        prod <= mul_p;
      end
      ST_CHECK: begin
        neg  <= acc[AW-1];
        mag  <= acc_mag[NW-1:0];
        dreg <= prod[DW-1:0];
        u    <= acc_mag[NW-1:0];
        v    <= {1'b0, prod[DW-1:0]};
        k    <= '0;
        if (bad_w) begin
          result <= '{sum_num: '0, sum_den: '0, same: same_w, bad_input: 1'b1};
        end else if (acc == '0) begin
          result <= '{sum_num: '0, sum_den: DW'(1), same: same_w, bad_input: 1'b0};
        end
      end
      ST_GCD: begin
        if (u == '0) begin
          g   <= v << k;
          rem <= '0;
          quo <= mag;
          cnt <= '0;
        end else if (!u[0] && !v[0]) begin
          u <= u >> 1;
          v <= v >> 1;
          k <= k + KW'(1);
        end else if (!u[0]) begin
          u <= u >> 1;
        end else if (!v[0]) begin
          v <= v >> 1;
        end else if (sub_borrow) begin
          u <= v;
          v <= u;
        end else begin
          u <= sub_d[NW-1:0];
        end
      end
      ST_DIV_N, ST_DIV_D: begin
        if (last_step) begin
          rem <= '0;
          cnt <= '0;
          if (state == ST_DIV_N) begin
            qnum <= quo_next;
            quo  <= {1'b0, dreg};
          end else begin
            result <= '{sum_num: neg ? -qnum : qnum, sum_den: quo_next[DW-1:0],
                        same: same_w, bad_input: 1'b0};
          end
        end else begin
          rem <= sub_borrow ? sub_a[NW-1:0] : sub_d[NW-1:0];
          quo <= quo_next;
          cnt <= cnt + CW'(1);
        end
      end
      default: begin
      end
    endcase
  end

  // result strobe only appears once the sequencer is back at idle
  assert property (@(posedge clk) disable iff (rst) done |-> state == ST_IDLE)
    else $error("done outside idle");

  // one transfer per item, never back-to-back strobes
  assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("done held longer than one cycle");

  // gcd loop keeps a nonzero divisor candidate
  assert property (@(posedge clk) disable iff (rst) state == ST_GCD |-> v != '0)
    else $error("gcd operand v is zero");

  // error results carry a zero sum
  assert property (@(posedge clk) disable iff (rst)
    done && result.bad_input |-> result.sum_num == '0 && result.sum_den == '0)
    else $error("bad input with nonzero sum");

endmodule
